// File: src/sbdf_pkg.sv
// ----------------------------------------------------------------------------
// sbdf_pkg: shared types and constants of the scan beam density filter
// Beam point record, queue status, CORDIC constants and count limits.
// ----------------------------------------------------------------------------
`default_nettype none

package sbdf_pkg;

  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int COORD_W = 18;
  localparam int COUNT_W = 11;
  localparam int CORDIC_W = 18;
  localparam int TRIG_W = 16;
  localparam int PROD_W = RANGE_W + TRIG_W + 1;

  localparam int MAX_BEAMS = 1024;
  localparam int COUNT_CAP_INT = (MAX_BEAMS > 2047) ? 2047 : MAX_BEAMS;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 18'sd19899;
  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 18'sd16384;
  localparam logic signed [CORDIC_W-1:0] HALF_TURN = 18'sd32768;
  localparam logic [3:0] LAST_STEP = 4'd14;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [RANGE_W-1:0]        range_mm;
    logic                      last_beam;
  } beam_pt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // arctangent of 2^-i in 16-bit binary angle units
  function automatic logic signed [CORDIC_W-1:0] atan_val(input logic [3:0] i);
    logic signed [CORDIC_W-1:0] v;
    unique case (i)
      4'd0:  v = 18'sd8192;
      4'd1:  v = 18'sd4836;
      4'd2:  v = 18'sd2555;
      4'd3:  v = 18'sd1297;
      4'd4:  v = 18'sd651;
      4'd5:  v = 18'sd326;
      4'd6:  v = 18'sd163;
      4'd7:  v = 18'sd81;
      4'd8:  v = 18'sd41;
      4'd9:  v = 18'sd20;
      4'd10: v = 18'sd10;
      4'd11: v = 18'sd5;
      4'd12: v = 18'sd3;
      4'd13: v = 18'sd1;
      4'd14: v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/sbdf_front.sv
// ----------------------------------------------------------------------------
// sbdf_front: beam intake and polar to Cartesian conversion
// Folds the angle, runs a 15-step CORDIC four steps per cycle, scales by the
// range with rounding and pushes the point into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdf_front
  import sbdf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [RANGE_W-1:0] in_range,
  input  wire logic [ANGLE_W-1:0] in_angle,
  input  wire logic               in_last,
  input  wire q_stat_t            q_stat,
  output logic                    q_push,
  output beam_pt_t                q_data
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_ROT  = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [1:0]                   cnt_r, cnt_nxt;
  logic signed [CORDIC_W-1:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                         neg_r, neg_nxt;
  logic [RANGE_W-1:0]           range_r, range_nxt;
  logic                         last_r, last_nxt;
  logic signed [PROD_W-1:0]     prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt;

  logic                         accept;
  logic signed [CORDIC_W-1:0]   rot_x, rot_y, rot_z;
  logic signed [TRIG_W-1:0]     cos_q, sin_q;
  logic signed [PROD_W:0]       rnd_x, rnd_y;

  function automatic logic signed [TRIG_W-1:0] clamp_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

  // four CORDIC steps per cycle; the sixteenth slot does nothing
  always_comb begin
    logic signed [CORDIC_W-1:0] xv, yv, zv, xs, ys;
    logic [3:0] idx;
    xv = x_r;
    yv = y_r;
    zv = z_r;
    for (int k = 0; k < 4; k++) begin
      idx = {cnt_r, 2'(k)};
      xs = xv >>> idx;
      ys = yv >>> idx;
      if (idx <= LAST_STEP) begin
        if (zv >= 0) begin
          xv = xv - ys;
          yv = yv + xs;
          zv = zv - atan_val(idx);
        end else begin
          xv = xv + ys;
          yv = yv - xs;
          zv = zv + atan_val(idx);
        end
      end
    end
    rot_x = xv;
    rot_y = yv;
    rot_z = zv;
  end

  assign cos_q = clamp_q15(neg_r ? -x_r : x_r);
  assign sin_q = clamp_q15(neg_r ? -y_r : y_r);

  // round to nearest, ties upward, then floor shift
  assign rnd_x = {prod_x_r[PROD_W-1], prod_x_r} + (PROD_W+1)'(16384);
  assign rnd_y = {prod_y_r[PROD_W-1], prod_y_r} + (PROD_W+1)'(16384);

  assign in_ready = (state_r == F_IDLE) || ((state_r == F_PUSH) && !q_stat.full);
  assign accept   = in_valid && in_ready;
  assign q_push   = (state_r == F_PUSH) && !q_stat.full;

  always_comb begin
    q_data.px        = rnd_x[15 +: COORD_W];
    q_data.py        = rnd_y[15 +: COORD_W];
    q_data.range_mm  = range_r;
    q_data.last_beam = last_r;
  end

  always_comb begin
    logic signed [CORDIC_W-1:0] ang;
    logic signed [PROD_W-1:0]   rng_e, cos_e, sin_e;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    neg_nxt    = neg_r;
    range_nxt  = range_r;
    last_nxt   = last_r;
    prod_x_nxt = prod_x_r;
    prod_y_nxt = prod_y_r;
    ang   = {{(CORDIC_W-ANGLE_W){in_angle[ANGLE_W-1]}}, in_angle};
    rng_e = {{(PROD_W-RANGE_W){1'b0}}, range_r};
    cos_e = {{(PROD_W-TRIG_W){cos_q[TRIG_W-1]}}, cos_q};
    sin_e = {{(PROD_W-TRIG_W){sin_q[TRIG_W-1]}}, sin_q};

    unique case (state_r)
      F_IDLE: begin
      end
      F_ROT: begin
        x_nxt   = rot_x;
        y_nxt   = rot_y;
        z_nxt   = rot_z;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        prod_x_nxt = rng_e * cos_e;
        prod_y_nxt = rng_e * sin_e;
        state_nxt  = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase

    if (accept) begin
      state_nxt = F_ROT;
      cnt_nxt   = 2'd0;
      x_nxt     = CORDIC_GAIN;
      y_nxt     = '0;
      range_nxt = in_range;
      last_nxt  = in_last;
      // fold into the right half plane, flip the result later
      if (ang > QUARTER_TURN) begin
        z_nxt   = ang - HALF_TURN;
        neg_nxt = 1'b1;
      end else if (ang < -QUARTER_TURN) begin
        z_nxt   = ang + HALF_TURN;
        neg_nxt = 1'b1;
      end else begin
        z_nxt   = ang;
        neg_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    neg_r    <= neg_nxt;
    range_r  <= range_nxt;
    last_r   <= last_nxt;
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
  end

endmodule

`default_nettype wire

// File: src/sbdf_queue.sv
// ----------------------------------------------------------------------------
// sbdf_queue: short point queue between front and back
// Register-based FIFO of converted beam points.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdf_queue
  import sbdf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire beam_pt_t push_data,
  input  wire logic     pop,
  output beam_pt_t      pop_data,
  output q_stat_t       stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  beam_pt_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/sbdf_back.sv
// ----------------------------------------------------------------------------
// sbdf_back: spacing decision and result register
// Squares the offset to the last kept point, compares with the squared
// spacing, updates the reference and the kept count, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdf_back
  import sbdf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [RANGE_W-1:0] cfg_wr_data,
  input  wire q_stat_t            q_stat,
  input  wire beam_pt_t           q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [RANGE_W-1:0]      out_range,
  output logic                    out_supp,
  output logic [COUNT_W-1:0]      out_count,
  output logic                    out_end
);

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = 2 * COORD_W - 1;
  localparam int LIM_W  = 2 * RANGE_W;

  typedef enum logic [1:0] {
    B_LOAD   = 2'b01,
    B_DECIDE = 2'b10
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [RANGE_W-1:0]          spacing_r;
  logic [LIM_W-1:0]            lim2_r;
  logic signed [COORD_W-1:0]   ref_x_r, ref_x_nxt, ref_y_r, ref_y_nxt;
  logic [COUNT_W-1:0]          kept_r, kept_nxt;
  logic [SUM_W-2:0]            sq_x_r, sq_y_r;
  beam_pt_t                    pt_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [RANGE_W-1:0]          out_range_r;
  logic                        out_supp_r;
  logic [COUNT_W-1:0]          out_count_r;
  logic                        out_end_r;

  logic signed [DIFF_W-1:0]    dx, dy;
  logic signed [SQ_W-1:0]      sqx, sqy;
  logic [SUM_W-1:0]            d2;
  logic                        supp, decide;

  assign q_pop = (state_r == B_LOAD) && !q_stat.empty;

  assign dx  = DIFF_W'(ref_x_r) - DIFF_W'(q_data.px);
  assign dy  = DIFF_W'(ref_y_r) - DIFF_W'(q_data.py);
  assign sqx = SQ_W'(dx) * SQ_W'(dx);
  assign sqy = SQ_W'(dy) * SQ_W'(dy);

  assign d2     = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign supp   = d2 < {{(SUM_W-LIM_W){1'b0}}, lim2_r};
  assign decide = (state_r == B_DECIDE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    ref_x_nxt     = ref_x_r;
    ref_y_nxt     = ref_y_r;
    kept_nxt      = kept_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      B_LOAD: begin
        if (!q_stat.empty) begin
          state_nxt = B_DECIDE;
        end
      end
      B_DECIDE: begin
        if (decide) begin
          state_nxt     = B_LOAD;
          out_valid_nxt = 1'b1;
          if (!supp) begin
            ref_x_nxt = pt_r.px;
            ref_y_nxt = pt_r.py;
            if (kept_r < COUNT_CAP) begin
              kept_nxt = kept_r + 1'b1;
            end
          end
          // start the next scan from the origin
          if (pt_r.last_beam) begin
            ref_x_nxt = '0;
            ref_y_nxt = '0;
          end
        end
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_LOAD;
      spacing_r   <= '0;
      lim2_r      <= '0;
      ref_x_r     <= '0;
      ref_y_r     <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        spacing_r <= cfg_wr_data;
      end
      lim2_r      <= spacing_r * spacing_r;
      ref_x_r     <= ref_x_nxt;
      ref_y_r     <= ref_y_nxt;
      kept_r      <= (decide && pt_r.last_beam) ? '0 : kept_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (q_pop) begin
      pt_r   <= q_data;
      sq_x_r <= sqx[SUM_W-2:0];
      sq_y_r <= sqy[SUM_W-2:0];
    end
    if (decide) begin
      out_range_r <= pt_r.range_mm;
      out_supp_r  <= supp;
      out_count_r <= kept_nxt;
      out_end_r   <= pt_r.last_beam;
    end
  end

  assign out_valid = out_valid_r;
  assign out_range = out_range_r;
  assign out_supp  = out_supp_r;
  assign out_count = out_count_r;
  assign out_end   = out_end_r;

endmodule

`default_nettype wire

// File: src/scan_beam_density_filter.sv
// ----------------------------------------------------------------------------
// scan_beam_density_filter: minimum-spacing decimation of a laser scan
// Converts beams to points and flags those too close to the last kept one.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one beam per item, range and angle in in_tdata, in_tlast
//   marking the final beam of a scan. Output stream: one result per beam,
//   range and kept count in out_tdata, suppressed flag in out_tuser, scan
//   end in out_tlast. cfg_wr_en/cfg_wr_data set the minimum spacing in mm;
//   write it only while no beam is in flight.
//   The front end sets the beam rate: it runs CORDIC at four steps per cycle,
//   then a multiply step and a push step, and takes the next beam as it
//   pushes the last one, unless the point queue is full. The back end
//   squares, then compares and updates the reference point, which it
//   overlaps with the front end.
//   Reset: reference point at the origin, kept count zero, spacing zero
//   (every beam kept), no results pending.
//   Stall: a result waits in the output register while the next beam is
//   accepted; the point queue fills, then in_tready drops.
//   After the final beam of a scan the reference and count start over.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_beam_density_filter
  import sbdf_pkg::*;
#(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,   // min_spacing
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // [15:0] range_mm, [31:16] beam_angle
  input  wire logic        in_tlast,      // last_beam
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,     // [15:0] range_out, [26:16] kept_count
  output logic             out_tuser,     // suppressed
  output logic             out_tlast      // scan_end
);

  q_stat_t            q_stat;
  beam_pt_t           push_data, pop_data;
  logic               q_push, q_pop;
  logic [RANGE_W-1:0] res_range;
  logic [COUNT_W-1:0] res_count;

  sbdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_range (in_tdata[15:0]),
    .in_angle (in_tdata[31:16]),
    .in_last  (in_tlast),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  sbdf_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  sbdf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_range   (res_range),
    .out_supp    (out_tuser),
    .out_count   (res_count),
    .out_end     (out_tlast)
  );

  assign out_tdata = {5'b0, res_count, res_range};

endmodule

`default_nettype wire

// File: verif/scan_beam_density_filter_checker.sv
// ----------------------------------------------------------------------------
// scan_beam_density_filter_checker: result predictor and scoreboard
// Watches the beam, result and spacing ports. For every accepted beam it
// works out the expected range, suppressed flag, kept count and scan end,
// then compares each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module scan_beam_density_filter_checker
  import sbdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARC_STEPS = 15;
  localparam int ARC_TAB[ARC_STEPS] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
  };
  localparam int TRIG_GAIN = 19899;
  localparam int QTR_TURN = 16384;
  localparam int HALF_TURN_I = 32768;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [RANGE_W-1:0] range_out;
    logic               suppressed;
    logic [COUNT_W-1:0] kept_count;
    logic               scan_end;
  } beam_result_t;

  beam_result_t beam_results_q[$];

  int spacing_mm = 0;
  int last_kept_x = 0;
  int last_kept_y = 0;
  int kept_in_scan = 0;
  int errs = 0;
  int in_flight_n = 0;

  assign mismatches = errs;
  assign in_flight = in_flight_n;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errs < MAX_PRINTS) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
    errs++;
  endtask

  // Q1.15 sine and cosine by shift-and-add rotation
  function automatic void beam_trig(input int angle, output int sin_q, output int cos_q);
    int  cx;
    int  cy;
    int  rz;
    int  xs;
    int  ys;
    bit  flip;
    cx = TRIG_GAIN;
    cy = 0;
    rz = angle;
    flip = 1'b0;
    // fold into the right half plane, negate at the end
    if (rz > QTR_TURN) begin
      rz -= HALF_TURN_I;
      flip = 1'b1;
    end else if (rz < -QTR_TURN) begin
      rz += HALF_TURN_I;
      flip = 1'b1;
    end
    for (int i = 0; i < ARC_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (rz >= 0) begin
        cx -= ys;
        cy += xs;
        rz -= ARC_TAB[i];
      end else begin
        cx += ys;
        cy -= xs;
        rz += ARC_TAB[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cos_q = (cx > 32767) ? 32767 : ((cx < -32768) ? -32768 : cx);
    sin_q = (cy > 32767) ? 32767 : ((cy < -32768) ? -32768 : cy);
  endfunction

  function automatic beam_result_t filter_beam(input logic [15:0] rng, input logic [15:0] ang,
                                               input logic last);
    beam_result_t res;
    int           sin_q;
    int           cos_q;
    int           pt_x;
    int           pt_y;
    longint       dx;
    longint       dy;
    longint       dist2;
    longint       lim2;
    beam_trig(int'($signed(ang)), sin_q, cos_q);
    pt_x = int'((longint'(rng) * cos_q + 16384) >>> 15);
    pt_y = int'((longint'(rng) * sin_q + 16384) >>> 15);
    dx = longint'(last_kept_x) - pt_x;
    dy = longint'(last_kept_y) - pt_y;
    dist2 = dx * dx + dy * dy;
    lim2 = longint'(spacing_mm) * spacing_mm;
    res.suppressed = (dist2 < lim2);
    if (!res.suppressed) begin
      last_kept_x = pt_x;
      last_kept_y = pt_y;
      if (kept_in_scan < COUNT_CAP_INT) kept_in_scan++;
    end
    res.range_out = rng;
    res.kept_count = COUNT_W'(kept_in_scan);
    res.scan_end = last;
    // next scan starts from the origin
    if (last) begin
      last_kept_x = 0;
      last_kept_y = 0;
      kept_in_scan = 0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    beam_result_t want;
    if (!rst_n) begin
      beam_results_q.delete();
      spacing_mm = 0;
      last_kept_x = 0;
      last_kept_y = 0;
      kept_in_scan = 0;
    end else begin
      // retire before predicting: a result never belongs to a beam of the same edge
      if (out_tvalid && out_tready) begin
        if (beam_results_q.size() == 0) begin
          report_mismatch("result with no beam pending, range", int'(out_tdata[15:0]), -1);
        end else begin
          want = beam_results_q.pop_front();
          if (out_tdata[15:0] !== want.range_out)
            report_mismatch("range_out", int'(out_tdata[15:0]), int'(want.range_out));
          if (out_tuser !== want.suppressed)
            report_mismatch("suppressed", int'(out_tuser), int'(want.suppressed));
          if (out_tdata[26:16] !== want.kept_count)
            report_mismatch("kept_count", int'(out_tdata[26:16]), int'(want.kept_count));
          if (out_tlast !== want.scan_end)
            report_mismatch("scan_end", int'(out_tlast), int'(want.scan_end));
        end
      end
      if (in_tvalid && in_tready) begin
        beam_results_q.push_back(filter_beam(in_tdata[15:0], in_tdata[31:16], in_tlast));
      end
      if (cfg_wr_en) spacing_mm = int'(cfg_wr_data);
    end
    in_flight_n = beam_results_q.size();
  end

endmodule

// File: verif/tb_scan_beam_density_filter.sv
// ----------------------------------------------------------------------------
// tb_scan_beam_density_filter: testbench top of the scan beam density filter
// Drives directed and random laser scans under several spacings, with random
// idling on both streams, a long output hold-off and a long saturating scan.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_scan_beam_density_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 7;
  localparam int PHASE_BEAMS = 140;
  localparam int LONG_SCAN = 1030;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int mismatches;
  int in_flight;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  scan_beam_density_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  scan_beam_density_filter_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // result side: random back-pressure, or a long counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic send_beam(input logic [15:0] rng, input logic [15:0] ang, input logic last);
    in_tvalid <= 1'b1;
    in_tdata <= {ang, rng};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!steady && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drop valid, wait for every result, then let the pipeline go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (in_flight == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_spacing(input logic [15:0] mm);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mm;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly a smooth sweep of nearby ranges, with some fully random beams mixed in
  task automatic send_scan(input int n_beams);
    int          angle;
    int          stride;
    int          base;
    int          jig;
    int          rng;
    logic [15:0] r16;
    logic [15:0] a16;
    angle = $urandom_range(0, 65535);
    stride = $urandom_range(1, 600);
    base = $urandom_range(0, 60000);
    jig = $urandom_range(0, 200);
    for (int k = 0; k < n_beams; k++) begin
      if ($urandom_range(99) < 85) begin
        angle += stride;
        rng = base + $urandom_range(0, jig);
        r16 = rng[15:0];
        a16 = angle[15:0];
      end else begin
        r16 = 16'($urandom);
        a16 = 16'($urandom);
      end
      send_beam(r16, a16, k == n_beams - 1);
    end
  endtask

  initial begin
    int spacing_plan[PHASES];
    int sent;
    int n;
    spacing_plan = '{0, 1, 65535, 40, 250, 0, 1200};
    spacing_plan[5] = $urandom_range(0, 65535);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset spacing keeps all: range extremes and the angle fold boundaries
    send_beam(16'd0, 16'h0000, 1'b0);
    send_beam(16'hFFFF, 16'h0000, 1'b0);
    send_beam(16'hFFFF, 16'h8000, 1'b0);
    send_beam(16'hFFFF, 16'h7FFF, 1'b0);
    send_beam(16'd1000, 16'h4000, 1'b0);
    send_beam(16'd1000, 16'hC000, 1'b0);
    send_beam(16'd1000, 16'h4001, 1'b0);
    send_beam(16'd1000, 16'hBFFF, 1'b1);

    // small spacing: origin beam, near beams suppressed, far ones kept
    settle();
    set_spacing(16'd100);
    send_beam(16'd0, 16'h0000, 1'b0);
    send_beam(16'd50, 16'h0000, 1'b0);
    send_beam(16'd150, 16'h0000, 1'b0);
    send_beam(16'd160, 16'h0000, 1'b0);
    send_beam(16'd150, 16'h2000, 1'b1);

    // largest spacing: every beam lies inside the limit and is suppressed
    settle();
    set_spacing(16'hFFFF);
    send_beam(16'hFFFF, 16'h0000, 1'b0);
    send_beam(16'hFFFE, 16'h7FFF, 1'b0);
    send_beam(16'd1, 16'h0000, 1'b0);
    send_beam(16'd0, 16'h8000, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_spacing(spacing_plan[p][15:0]);
      steady = (p == 4);
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BEAMS) begin
        n = $urandom_range(1, 40);
        send_scan(n);
        sent += n;
      end
    end

    // one scan long enough to saturate the kept count
    settle();
    steady = 1'b0;
    set_spacing(16'd0);
    send_scan(LONG_SCAN);
    send_scan(3);

    settle();
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_scan_beam_density_filter: PASS");
    end else begin
      $display("tb_scan_beam_density_filter: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_scan_beam_density_filter: FAIL");
    $finish;
  end

endmodule
